// ----- hw/rtl/vibrato_pitch_shift_delay_line_macros.svh -----
// Assertion helpers shared by the delay line RTL.
`ifndef VIBRATO_PITCH_SHIFT_DELAY_LINE_MACROS_SVH
`define VIBRATO_PITCH_SHIFT_DELAY_LINE_MACROS_SVH
`ifndef SYNTHESIS
`define VPSDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define VPSDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define VPSDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VPSDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/vpsdl_pkg.sv -----
package vpsdl_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int CFG_BITS    = 22;
	localparam int STEP_BITS   = 22;
	localparam int DEPTH_BITS  = 17;
	localparam int SHIFT_BITS  = 21;
	localparam int PHASE_BITS  = 32;
	localparam int EXP_BITS    = 22;
	localparam int QUOT_BITS   = 18;

	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [16:0] HORNER_0 = 17'd5159;
	localparam logic [16:0] HORNER_1 = 17'd14824;
	localparam logic [16:0] HORNER_2 = 17'd45553;
	localparam logic [22:0] EXP_BIAS = 23'd1572864;
	localparam logic [4:0]  DIV_CONST = 5'd12;

	typedef enum logic [1:0] {
		CFG_LFO_STEP    = 2'd0,
		CFG_VIB_DEPTH   = 2'd1,
		CFG_PITCH_SHIFT = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD0, ST_RD1, ST_WR, ST_SINE, ST_DEPTH, ST_DIV,
		ST_HORN1, ST_HORN2, ST_HORN3, ST_INT_L, ST_INT_R, ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_left;
		logic signed [SAMPLE_BITS-1:0] in_right;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
	} out_item_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

// ----- hw/rtl/vpsdl_mul.sv -----
// Shift-add multiplier: signed multiplicand, unsigned multiplier, one bit per cycle.
module vpsdl_mul import vpsdl_pkg::*; #(
	parameter int AW = 25,
	parameter int BW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic [BW-1:0]        b,
	output unit_status_t         stat,
	output logic signed [AW+BW:0] prod
);
	localparam int CW = $clog2(BW + 1);

	logic signed [AW:0]   hi_q;
	logic [BW-1:0]        lo_q;
	logic signed [AW-1:0] a_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [AW:0]   sum;

	assign sum = hi_q + (lo_q[0] ? {a_q[AW-1], a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {sum[AW], sum[AW:1]};
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = {hi_q, lo_q};
endmodule

// ----- hw/rtl/vpsdl_div.sv -----
// Restoring division by twelve, one quotient bit per cycle.
module vpsdl_div import vpsdl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [EXP_BITS-1:0]  dividend,
	output unit_status_t         stat,
	output logic [QUOT_BITS-1:0] quot
);
	logic [3:0]          rem_q;
	logic [EXP_BITS-1:0] num_q;
	logic [4:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [4:0]          trial;
	logic                ge;

	assign trial = {rem_q, num_q[EXP_BITS-1]};
	assign ge    = (trial >= DIV_CONST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(EXP_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			num_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? 4'(trial - DIV_CONST) : trial[3:0];
			num_q <= {num_q[EXP_BITS-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = num_q[QUOT_BITS-1:0];
endmodule

// ----- hw/rtl/vpsdl_mem.sv -----
// Single-port sample store with a clearing sweep after reset.
module vpsdl_mem import vpsdl_pkg::*; #(
	parameter int DEPTH = 480,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mem_cmd_t                   cmd,
	input  logic [AW-1:0]              addr,
	input  logic [2*SAMPLE_BITS-1:0]   wdata,
	output logic [2*SAMPLE_BITS-1:0]   rdata,
	output logic                       busy
);
	logic [2*SAMPLE_BITS-1:0] mem [DEPTH];
	logic [2*SAMPLE_BITS-1:0] rdata_q;
	logic [AW-1:0]            clr_cnt_q;
	logic                     clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(DEPTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_cnt_q] <= '0;
		else if (cmd.wr)
			mem[addr] <= wdata;
		if (cmd.rd)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;
endmodule

// ----- hw/rtl/vibrato_pitch_shift_delay_line.sv -----
// Stereo vibrato / pitch-shift delay line. Each input transfer carries one
// left/right sample pair; each output transfer returns the line read at the
// fractional read position, linearly interpolated with the next entry, before
// the new pair is stored. The read position then advances by
// 2^((pitch_shift + vibrato_depth*sin(lfo))/12) and the LFO phase by lfo_step.
// Items do not overlap: input is stalled from one input transfer until the
// result has moved into the output register. The bit-serial multiplier (one
// multiplier bit a cycle, seven products an item) and the divide by twelve
// set the time an item takes.
// After reset every entry of the store is cleared, and input is stalled
// meanwhile; configuration writes are taken at any time.
`include "vibrato_pitch_shift_delay_line_macros.svh"
module vibrato_pitch_shift_delay_line import vpsdl_pkg::*; #(
	parameter int LINE_LENGTH   = 480,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);
	localparam int AW     = $clog2(LINE_LENGTH);
	localparam int RPW    = AW + FRACTION_BITS;
	localparam int MUL_AW = (SAMPLE_BITS + 1 > 18) ? SAMPLE_BITS + 1 : 18;
	localparam int MUL_BW = (FRACTION_BITS > 17) ? FRACTION_BITS : 17;
	localparam int PW     = MUL_AW + MUL_BW + 1;
	localparam int SHL    = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
	localparam int SHR    = (FRACTION_BITS >= 16) ? 0 : 16 - FRACTION_BITS;
	localparam int STW    = 18 + SHL;
	localparam logic [RPW:0]  SPAN     = (RPW + 1)'(LINE_LENGTH) << FRACTION_BITS;
	localparam logic [AW-1:0] LAST_IDX = AW'(LINE_LENGTH - 1);

	state_t state_q, state_d;

	// configuration
	logic [STEP_BITS-1:0]         lfo_step_q;
	logic [DEPTH_BITS-1:0]        depth_q;
	logic signed [SHIFT_BITS-1:0] shift_q;

	// per-item state and working registers
	in_item_t                 in_q;
	out_item_t                res_q;
	out_item_t                out_q;
	logic                     out_valid_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic [RPW-1:0]           rp_q;
	logic [AW-1:0]            wi_q;
	logic [2*SAMPLE_BITS-1:0] a_q, b_q;
	logic [16:0]              smag_q;
	logic [18:0]              mag_q;
	logic [1:0]               n_q;
	logic [15:0]              f_q;
	logic [16:0]              m_q;

	// datapath
	logic [AW-1:0]                p0, p1;
	logic [FRACTION_BITS-1:0]     frac;
	logic [19:0]                  mant_sh;
	logic [17:0]                  ratio;
	logic [STW-1:0]               step;
	logic [RPW:0]                 rp_sum;
	logic [RPW-1:0]               rp_next;
	logic [22:0]                  exp_sum;
	logic signed [SAMPLE_BITS:0]  diff_l, diff_r;
	logic signed [PW-1:0]         prod_sh;
	logic                         load_out;

	// unit hookup
	mem_cmd_t                     mem_cmd;
	logic [AW-1:0]                mem_addr;
	logic [2*SAMPLE_BITS-1:0]     mem_rdata;
	logic                         mem_busy;
	logic                         mul_start;
	logic signed [MUL_AW-1:0]     mul_a;
	logic [MUL_BW-1:0]            mul_b;
	logic signed [PW-1:0]         mul_prod;
	unit_status_t                 mul_stat;
	logic                         div_start;
	logic [QUOT_BITS-1:0]         div_quot;
	unit_status_t                 div_stat;

	vpsdl_mem #(.DEPTH(LINE_LENGTH)) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata ({in_q.in_left, in_q.in_right}),
		.rdata (mem_rdata),
		.busy  (mem_busy)
	);

	vpsdl_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.stat  (mul_stat),
		.prod  (mul_prod)
	);

	vpsdl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(exp_sum[EXP_BITS-1:0]),
		.stat    (div_stat),
		.quot    (div_quot)
	);

	// read taps: integer part and its successor, wrapping at the line end
	assign p0   = rp_q[RPW-1:FRACTION_BITS];
	assign p1   = (p0 == LAST_IDX) ? '0 : p0 + 1'b1;
	assign frac = rp_q[FRACTION_BITS-1:0];

	// ratio = (mantissa << octave) >> 2, then scale to the position format
	assign mant_sh = {3'b000, m_q} << n_q;
	assign ratio   = mant_sh[19:2];
	assign step    = (STW'(ratio) << SHL) >> SHR;
	assign rp_sum  = {1'b0, rp_q} + (RPW + 1)'(step);
	assign rp_next = (rp_sum >= SPAN) ? RPW'(rp_sum - SPAN) : rp_sum[RPW-1:0];

	// biased exponent in Q16 semitones, always positive
	assign exp_sum = 23'(shift_q) + (phase_q[31] ? -23'(mag_q) : 23'(mag_q)) + EXP_BIAS;

	assign diff_l = (SAMPLE_BITS + 1)'($signed(b_q[2*SAMPLE_BITS-1:SAMPLE_BITS]))
		- (SAMPLE_BITS + 1)'($signed(a_q[2*SAMPLE_BITS-1:SAMPLE_BITS]));
	assign diff_r = (SAMPLE_BITS + 1)'($signed(b_q[SAMPLE_BITS-1:0]))
		- (SAMPLE_BITS + 1)'($signed(a_q[SAMPLE_BITS-1:0]));
	assign prod_sh = mul_prod >>> FRACTION_BITS;

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		mem_cmd  = '0;
		mem_addr = p0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !mem_busy)
					state_d = ST_RD0;
			end
			ST_RD0: begin
				mem_cmd.rd = 1'b1;
				state_d    = ST_RD1;
			end
			ST_RD1: begin
				mem_cmd.rd = 1'b1;
				mem_addr   = p1;
				state_d    = ST_WR;
			end
			ST_WR: begin
				mem_cmd.wr = 1'b1;
				mem_addr   = wi_q;
				state_d    = ST_SINE;
			end
			ST_SINE: begin
				mul_a = MUL_AW'(phase_q[30:15]);
				mul_b = MUL_BW'(ONE_Q16 - 17'(phase_q[30:15]));
				if (mul_stat.done)
					state_d = ST_DEPTH;
			end
			ST_DEPTH: begin
				mul_a = MUL_AW'(depth_q);
				mul_b = MUL_BW'(smag_q);
				if (mul_stat.done)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done)
					state_d = ST_HORN1;
			end
			ST_HORN1: begin
				mul_a = MUL_AW'(m_q);
				mul_b = MUL_BW'(f_q);
				if (mul_stat.done)
					state_d = ST_HORN2;
			end
			ST_HORN2: begin
				mul_a = MUL_AW'(m_q);
				mul_b = MUL_BW'(f_q);
				if (mul_stat.done)
					state_d = ST_HORN3;
			end
			ST_HORN3: begin
				mul_a = MUL_AW'(m_q);
				mul_b = MUL_BW'(f_q);
				if (mul_stat.done)
					state_d = ST_INT_L;
			end
			ST_INT_L: begin
				mul_a = MUL_AW'(diff_l);
				mul_b = MUL_BW'(frac);
				if (mul_stat.done)
					state_d = ST_INT_R;
			end
			ST_INT_R: begin
				mul_a = MUL_AW'(diff_r);
				mul_b = MUL_BW'(frac);
				if (mul_stat.done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// launch a unit on the first cycle of its state; the done pulse moves on
	assign mul_start = (state_q == ST_SINE || state_q == ST_DEPTH || state_q == ST_HORN1
		|| state_q == ST_HORN2 || state_q == ST_HORN3 || state_q == ST_INT_L
		|| state_q == ST_INT_R) && !mul_stat.busy && !mul_stat.done;
	assign div_start = (state_q == ST_DIV) && !div_stat.busy && !div_stat.done;

	// configuration port: unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_step_q <= '0;
			depth_q    <= '0;
			shift_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LFO_STEP:    lfo_step_q <= cfg_data[STEP_BITS-1:0];
				CFG_VIB_DEPTH:   depth_q    <= cfg_data[DEPTH_BITS-1:0];
				CFG_PITCH_SHIFT: shift_q    <= cfg_data[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// positions advance only when the result is handed to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			rp_q        <= '0;
			wi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				phase_q     <= phase_q + PHASE_BITS'(lfo_step_q);
				rp_q        <= rp_next;
				wi_q        <= (wi_q == LAST_IDX) ? '0 : wi_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !mem_busy)
			in_q <= in_data;
		if (state_q == ST_WR)
			b_q <= mem_rdata;
		if (state_q == ST_RD1)
			a_q <= mem_rdata;
		if (mul_stat.done) begin
			case (state_q)
				ST_SINE:  smag_q <= mul_prod[30:14];
				ST_DEPTH: mag_q  <= mul_prod[34:16];
				ST_HORN1: m_q    <= HORNER_1 + mul_prod[32:16];
				ST_HORN2: m_q    <= HORNER_2 + mul_prod[32:16];
				ST_HORN3: m_q    <= ONE_Q16 + mul_prod[32:16];
				ST_INT_L: res_q.out_left <= $signed(a_q[2*SAMPLE_BITS-1:SAMPLE_BITS])
					+ $signed(prod_sh[SAMPLE_BITS-1:0]);
				ST_INT_R: res_q.out_right <= $signed(a_q[SAMPLE_BITS-1:0])
					+ $signed(prod_sh[SAMPLE_BITS-1:0]);
				default: ;
			endcase
		end
		if (div_stat.done) begin
			n_q <= div_quot[17:16];
			f_q <= div_quot[15:0];
			m_q <= HORNER_0;
		end
		// hold a stalled result; take the new one only when it moves out
		if (load_out)
			out_q <= res_q;
	end

	assign in_stall  = (state_q != ST_IDLE) || mem_busy;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`VPSDL_ASSERT_NXT(a_hold_after_take, clk, arst_n, in_valid && !in_stall, in_stall)
	`VPSDL_ASSERT_IMP(a_clear_blocks, clk, arst_n, mem_busy, in_stall)
	`VPSDL_ASSERT_IMP(a_rp_in_span, clk, arst_n, 1'b1, {1'b0, rp_q} < SPAN)
	`VPSDL_ASSERT_IMP(a_wi_in_line, clk, arst_n, 1'b1, wi_q <= LAST_IDX)
endmodule

// ----- tb/testbench.sv -----
module testbench;
	import vpsdl_pkg::*;

	localparam int LINE_LEN = 480;
	localparam int FRAC = 16;
	localparam longint SPAN = longint'(LINE_LEN) << FRAC;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 250;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int NUM_PHASES = 8;
	localparam int HOLD_CYCLES = 3000;
	// index with no register behind it; writes to it must be dropped
	localparam logic [1:0] CFG_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	vibrato_pitch_shift_delay_line u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the delay line state and the registers.
	longint line_l [LINE_LEN];
	longint line_r [LINE_LEN];
	int write_idx;
	longint read_pos;
	logic [31:0] lfo_phase;
	logic [STEP_BITS-1:0] lfo_step;
	logic [DEPTH_BITS-1:0] vib_depth;
	logic signed [SHIFT_BITS-1:0] pitch_shift;

	out_item_t delayed_q[$];
	int errors;
	int n_out;
	bit rx_idle_on;
	bit hold_done;
	int hold_cnt;
	int stall_cnt;
	int quiet_cycles;

	typedef struct {
		in_item_t din;
		bit typed;
		out_item_t dout;
	} stim_row_t;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Linear interpolation with a floor shift.
	function automatic longint lerp(longint a, longint b, longint w);
		longint acc;
		acc = a * ((longint'(1) << FRAC) - w) + b * w;
		return acc >>> FRAC;
	endfunction

	// Compute the delayed output for one sample pair and advance the shadow state.
	function automatic out_item_t delay_line_out(in_item_t x);
		longint rp, frac, u, s, mag, md, e, big, n, f, m;
		int p0, p1;
		out_item_t r;
		rp = read_pos % SPAN;
		p0 = int'((rp >> FRAC) % LINE_LEN);
		p1 = (p0 + 1) % LINE_LEN;
		frac = rp & ((longint'(1) << FRAC) - 1);
		r.out_left = SAMPLE_BITS'(lerp(line_l[p0], line_l[p1], frac));
		r.out_right = SAMPLE_BITS'(lerp(line_r[p0], line_r[p1], frac));
		// read happens before the write, so a collision returns the old entry
		line_l[write_idx] = longint'(x.in_left);
		line_r[write_idx] = longint'(x.in_right);
		// parabolic sine of the LFO phase
		u = longint'(lfo_phase[30:15]);
		s = (u * (65536 - u)) >> 14;
		if (lfo_phase[31]) s = -s;
		mag = (longint'(vib_depth) * (s < 0 ? -s : s)) >> 16;
		md = (s < 0) ? -mag : mag;
		e = longint'(pitch_shift) + md;
		// 2^(e/12): octave count and Horner mantissa
		big = e + 24 * 65536;
		n = big / (12 * 65536);
		f = (big % (12 * 65536)) / 12;
		m = 5159;
		m = 14824 + ((m * f) >> 16);
		m = 45553 + ((m * f) >> 16);
		m = 65536 + ((m * f) >> 16);
		read_pos = (rp + ((m << (n & 7)) >> 2)) % SPAN;
		write_idx = (write_idx + 1) % LINE_LEN;
		lfo_phase = lfo_phase + 32'(lfo_step);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2: return '0;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Write the three registers back to back, plus an ignored index, then drop we.
	task automatic load_regs(logic [STEP_BITS-1:0] st, logic [DEPTH_BITS-1:0] dp,
			logic signed [SHIFT_BITS-1:0] sh);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LFO_STEP;
		cfg_data <= CFG_BITS'(st);
		@(posedge clk);
		cfg_index <= CFG_VIB_DEPTH;
		cfg_data <= CFG_BITS'(dp);
		@(posedge clk);
		cfg_index <= CFG_PITCH_SHIFT;
		cfg_data <= CFG_BITS'(unsigned'(sh));
		@(posedge clk);
		cfg_index <= CFG_NONE;
		cfg_data <= CFG_BITS'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		lfo_step = st;
		vib_depth = dp;
		pitch_shift = sh;
	endtask

	// Offer one pair, hold it until accepted, then queue the prediction.
	task automatic push_sample(in_item_t x, bit typed, out_item_t want);
		out_item_t got;
		int gap;
		in_data <= x;
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		got = delay_line_out(x);
		delayed_q.push_back(typed ? want : got);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain everything, then let the block finish its state update.
	task automatic drain();
		in_valid <= 1'b0;
		wait (delayed_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: check every transfer, stall at random, one long hold-off.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_out++;
				if (delayed_q.size() == 0) begin
					$display("%0t: unexpected output %h", $time, out_data);
					errors++;
				end else begin
					want = delayed_q.pop_front();
					if (out_data.out_left !== want.out_left) begin
						$display("%0t: out_left expected %0d got %0d", $time,
							want.out_left, out_data.out_left);
						errors++;
					end
					if (out_data.out_right !== want.out_right) begin
						$display("%0t: out_right expected %0d got %0d", $time,
							want.out_right, out_data.out_right);
						errors++;
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (!hold_done && n_out >= 400) begin
				// long hold-off so the block backs up into its input
				hold_done = 1'b1;
				hold_cnt = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_stall <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
				stall_cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300)
					: $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		in_item_t x;
		logic [STEP_BITS-1:0] st;
		logic [DEPTH_BITS-1:0] dp;
		logic signed [SHIFT_BITS-1:0] sh;
		logic signed [SAMPLE_BITS-1:0] pat[8];

		errors = 0;
		n_out = 0;
		hold_done = 1'b0;
		hold_cnt = 0;
		stall_cnt = 0;
		quiet_cycles = 0;
		rx_idle_on = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LFO_STEP;
		cfg_data = '0;
		for (int i = 0; i < LINE_LEN; i++) begin
			line_l[i] = 0;
			line_r[i] = 0;
		end
		write_idx = 0;
		read_pos = 0;
		lfo_phase = '0;
		lfo_step = '0;
		vib_depth = '0;
		pitch_shift = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Fresh line at unit ratio: the read trails the write by a full line,
		// so every early output is zero, including the read-equals-write case.
		pat = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
			24'h555555, 24'hAAAAAA, 24'h000001, 24'h7FFFFE};
		for (int i = 0; i < 20; i++) begin
			row.din.in_left = pat[i % 8];
			row.din.in_right = pat[(i + 3) % 8];
			row.typed = 1'b1;
			row.dout = '0;
			rows.push_back(row);
		end
		foreach (rows[i]) push_sample(rows[i].din, rows[i].typed, rows[i].dout);
		// sender pause: wait until every output is back
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin st = 22'd2684355; dp = 17'd65536; sh = -21'sd786432; end
				1: begin st = '1; dp = '1; sh = 21'sd786432; end
				2: begin st = '0; dp = '0; sh = {1'b1, 20'd0}; end
				3: begin st = 22'd100000; dp = 17'd30000; sh = {1'b0, {20{1'b1}}}; end
				default: begin
					st = STEP_BITS'($urandom_range(0, 2684355));
					dp = DEPTH_BITS'($urandom_range(0, 65536));
					sh = SHIFT_BITS'(int'($urandom_range(0, 1572864)) - 786432);
				end
			endcase
			load_regs(st, dp, sh);
			rx_idle_on = (ph % 3 != 2);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				x.in_left = pick_sample();
				x.in_right = pick_sample();
				push_sample(x, 1'b0, '0);
			end
			drain();
		end

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/vpsdl_pkg.sv
hw/rtl/vpsdl_mul.sv
hw/rtl/vpsdl_div.sv
hw/rtl/vpsdl_mem.sv
hw/rtl/vibrato_pitch_shift_delay_line.sv
tb/testbench.sv
